/* src/dccr_pkg.sv */
package dccr_pkg;

  localparam int unsigned HdrBytes    = 20;
  localparam int unsigned AvpBaseHdr  = 8;
  localparam int unsigned VendorExtra = 4;
  localparam int unsigned QDepth      = 4;
  localparam int unsigned QAw         = $clog2(QDepth);

  localparam logic [23:0] CmdReset = 24'd272;
  localparam logic [31:0] AppReset = 32'd4;

  typedef enum logic [1:0] {
    KIND_AVP    = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    RSN_HEADER = 2'd0,
    RSN_SHORT  = 2'd1,
    RSN_BADLEN = 2'd2
  } reason_t;

  localparam logic [0:0] REG_CMD = 1'b0;
  localparam logic [0:0] REG_APP = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] avp_code;
    logic [23:0] avp_data_len;
    logic [23:0] data_offset;
    logic [23:0] msg_len;
    logic [1:0]  reject_reason;
  } result_t;

endpackage

/* src/dccr_if.sv */
interface dccr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;
  modport source (output valid, data_byte, buffer_end, input ready);
  modport sink (input valid, data_byte, buffer_end, output ready);
endinterface

interface dccr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] avp_code;
  logic [23:0] avp_data_len;
  logic [23:0] data_offset;
  logic [23:0] msg_len;
  logic [1:0]  reject_reason;
  modport source (output valid, kind, avp_code, avp_data_len, data_offset, msg_len,
                  reject_reason, input ready);
  modport sink (input valid, kind, avp_code, avp_data_len, data_offset, msg_len,
                reject_reason, output ready);
endinterface

/* src/dccr_walker.sv */
module dccr_walker
  import dccr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_valid,
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  input  logic [23:0] cmd_code,
  input  logic [31:0] app_id,
  output logic        res_valid,
  output result_t     res
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_WALK, PH_SHORT, PH_BADLEN, PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [23:0] off_r, off_nxt;
  logic [23:0] mlen_r, mlen_nxt;
  logic [31:0] shift_r;
  logic [31:0] code_r, code_nxt;
  logic        vend_r, vend_nxt;
  logic [23:0] nstart_r, nstart_nxt;

  logic [31:0] sh;
  logic [23:0] rel, room, len, hdr, dlen, stp;
  logic        bad, found, emit;

  always_comb begin
    sh         = {shift_r[23:0], data_byte};
    phase_nxt  = phase_r;
    off_nxt    = off_r;
    mlen_nxt   = mlen_r;
    code_nxt   = code_r;
    vend_nxt   = vend_r;
    nstart_nxt = nstart_r;
    res        = '0;
    emit       = 1'b0;
    found      = 1'b0;
    bad        = 1'b0;
    rel        = off_r - nstart_r;
    room       = mlen_r - nstart_r;
    len        = sh[23:0];
    hdr        = vend_r ? 24'(AvpBaseHdr + VendorExtra) : 24'(AvpBaseHdr);
    dlen       = len - hdr;
    stp        = (len + 24'd3) & ~24'd3;
    if (phase_r == PH_DONE) begin
      // drop bytes until the buffer ends
    end else if (phase_r == PH_HEADER) begin
      if (off_r == 24'd0 && data_byte != 8'd1) bad = 1'b1;
      if (off_r == 24'd3) begin
        mlen_nxt = sh[23:0];
        if (sh[23:0] < 24'(HdrBytes) || sh[1:0] != 2'b00) bad = 1'b1;
      end
      if (off_r == 24'd4 && !data_byte[7]) bad = 1'b1;
      if (off_r == 24'd7 && sh[23:0] != cmd_code) bad = 1'b1;
      if (off_r == 24'd11 && sh != app_id) bad = 1'b1;
      if (bad || (buffer_end && !(off_r == 24'd19 && mlen_r == 24'(HdrBytes)))) begin
        emit = 1'b1;
        res.kind = KIND_REJECT;
        res.reject_reason = RSN_HEADER;
      end else if (off_r == 24'd19) begin
        if (mlen_r == 24'(HdrBytes)) begin
          emit = 1'b1;
          res.kind = KIND_ACCEPT;
          res.msg_len = mlen_r;
        end else begin
          phase_nxt  = PH_WALK;
          nstart_nxt = 24'(HdrBytes);
        end
      end
    end else begin
      if (phase_r == PH_WALK && off_r >= nstart_r) begin
        if (rel == 24'd0 && room < 24'(AvpBaseHdr)) phase_nxt = PH_SHORT;
        else if (rel == 24'd3) code_nxt = sh;
        else if (rel == 24'd4) vend_nxt = data_byte[7];
        else if (rel == 24'd7) begin
          if (len < hdr || len > room) phase_nxt = PH_BADLEN;
          else begin
            found = 1'b1;
            res.avp_code     = code_r;
            res.avp_data_len = dlen;
            res.data_offset  = nstart_r + hdr;
            nstart_nxt = (stp > room) ? mlen_r : nstart_r + stp;
          end
        end
      end
      if (off_r + 24'd1 != mlen_r) begin
        if (buffer_end) begin
          emit = 1'b1;
          res = '0;
          res.kind = KIND_REJECT;
        end else if (found) begin
          emit = 1'b1;
          res.kind = KIND_AVP;
        end
      end else if (phase_nxt == PH_WALK || (phase_r == PH_WALK && found)) begin
        emit = 1'b1;
        res.kind = KIND_ACCEPT;
        res.msg_len = mlen_r;
      end else begin
        emit = 1'b1;
        res = '0;
        res.kind = KIND_REJECT;
        res.reject_reason = (phase_nxt == PH_SHORT) ? RSN_SHORT : RSN_BADLEN;
      end
    end
    if (emit && !(res.kind == KIND_AVP)) phase_nxt = PH_DONE;
    else if (!emit || res.kind == KIND_AVP) off_nxt = off_r + 24'd1;
  end

  assign res_valid = byte_valid && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      off_r    <= '0;
      mlen_r   <= '0;
      shift_r  <= '0;
      code_r   <= '0;
      vend_r   <= 1'b0;
      nstart_r <= 24'(HdrBytes);
    end else if (byte_valid) begin
      if (buffer_end) begin
        phase_r  <= PH_HEADER;
        off_r    <= '0;
        mlen_r   <= '0;
        shift_r  <= '0;
        code_r   <= '0;
        vend_r   <= 1'b0;
        nstart_r <= 24'(HdrBytes);
      end else begin
        phase_r  <= phase_nxt;
        off_r    <= off_nxt;
        mlen_r   <= mlen_nxt;
        if (phase_r != PH_DONE) shift_r <= sh;
        code_r   <= code_nxt;
        vend_r   <= vend_nxt;
        nstart_r <= nstart_nxt;
      end
    end
  end

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |-> !emit) else $error("result after verdict");
  a_hdr_no_avp: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER && emit) |-> res.kind != KIND_AVP) else $error("avp in header");
  a_nstart: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WALK) |-> nstart_r >= 24'(HdrBytes)) else $error("avp start low");

endmodule

/* src/dccr_queue.sv */
module dccr_queue
  import dccr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    has_room,
  dccr_out_if.source out_ch
);

  result_t        mem_r [QDepth];
  logic [QAw-1:0] wp_r, rp_r;
  logic [QAw:0]   cnt_r;
  logic           pop;

  assign has_room = cnt_r < (QAw+1)'(QDepth - 1);
  assign pop      = out_ch.valid && out_ch.ready;
  assign out_ch.valid = cnt_r != '0;
  assign out_ch.kind          = mem_r[rp_r].kind;
  assign out_ch.avp_code      = mem_r[rp_r].avp_code;
  assign out_ch.avp_data_len  = mem_r[rp_r].avp_data_len;
  assign out_ch.data_offset   = mem_r[rp_r].data_offset;
  assign out_ch.msg_len       = mem_r[rp_r].msg_len;
  assign out_ch.reject_reason = mem_r[rp_r].reject_reason;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAw+1)'(push) - (QAw+1)'(pop);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r < (QAw+1)'(QDepth)) else $error("queue overflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAw+1)'(QDepth)) else $error("queue count");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count step");

endmodule

/* src/diameter_ccr_avp_parser.sv */
// Diameter request parser: one message byte per word, one word per cycle sustained.
// The header walker decides each byte in the cycle it is accepted and pushes at most
// one result word into a 4-entry queue; input stalls only while that queue holds 3 or
// more words. Results come out in order, one per cycle, as the sink takes them.
// Registers: 0x0 command code (24 bits), 0x4 application id; write while idle.
module diameter_ccr_avp_parser
  import dccr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dccr_in_if.sink     in_ch,
  dccr_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [23:0] cmd_r;
  logic [31:0] app_r;
  logic        room, wvalid, rvalid;
  result_t     res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_APP) ? app_r : {8'd0, cmd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= CmdReset;
      app_r <= AppReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_CMD) cmd_r <= cfg_pwdata[23:0];
      else app_r <= cfg_pwdata;
    end
  end

  assign in_ch.ready = room;
  assign wvalid      = in_ch.valid && room;

  dccr_walker u_walker (
    .clk, .rst_n, .byte_valid(wvalid), .data_byte(in_ch.data_byte),
    .buffer_end(in_ch.buffer_end), .cmd_code(cmd_r), .app_id(app_r),
    .res_valid(rvalid), .res(res)
  );

  dccr_queue u_queue (
    .clk, .rst_n, .push(rvalid), .push_data(res), .has_room(room), .out_ch(out_ch)
  );

endmodule

/* bench/diameter_ccr_avp_parser_tb.sv */
`timescale 1ns / 100ps

module diameter_ccr_avp_parser_tb;
  import dccr_pkg::*;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_WALK   = 3'd1;
  localparam logic [2:0] PH_SHORT  = 3'd2;
  localparam logic [2:0] PH_BADLEN = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;
  localparam int unsigned MASK24   = 32'hFFFFFF;

  typedef struct {
    logic [7:0] b;
    logic       e;
  } msg_byte_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  dccr_in_if  in_ch ();
  dccr_out_if out_ch ();

  diameter_ccr_avp_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  msg_byte_t   byte_stream[$];
  result_t     results_due[$];
  bit          failed;
  bit          in_fire;
  bit          calm;
  int          in_gap;
  int          out_stall;
  int          bytes_sent;

  // parser state mirror
  logic [23:0] cmd_reg;
  logic [31:0] app_reg;
  logic [2:0]  ph;
  int unsigned off;
  int unsigned mlen;
  int unsigned shf;
  int unsigned acode;
  int unsigned vbit;
  int unsigned nstart;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic void walker_restart();
    ph = PH_HEADER;
    off = 0;
    mlen = 0;
    shf = 0;
    acode = 0;
    vbit = 0;
    nstart = 20;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output result_t r);
    int unsigned o;
    int unsigned s;
    int unsigned rel;
    int unsigned room;
    int unsigned len;
    int unsigned hdr;
    int unsigned stp;
    bit          bad;
    bit          found;
    bit          n;
    int unsigned f_code;
    int unsigned f_dlen;
    int unsigned f_doff;
    o = off;
    found = 0;
    n = 0;
    f_code = 0;
    f_dlen = 0;
    f_doff = 0;
    r = '0;
    if (ph == PH_DONE) begin
      if (last) walker_restart();
      return 0;
    end
    shf = (shf << 8) | b;
    if (ph == PH_HEADER) begin
      bad = 0;
      if (o == 0 && b != 8'd1) bad = 1;
      if (o == 3) begin
        mlen = shf & MASK24;
        if (mlen < 20 || (mlen & 3) != 0) bad = 1;
      end
      if (o == 4 && b[7] == 1'b0) bad = 1;
      if (o == 7 && (shf & MASK24) != cmd_reg) bad = 1;
      if (o == 11 && shf != app_reg) bad = 1;
      if (bad || (last && !(o == 19 && mlen == 20))) begin
        r.kind = KIND_REJECT;
        r.reject_reason = RSN_HEADER;
        n = 1;
      end else if (o == 19) begin
        if (mlen == 20) begin
          r.kind = KIND_ACCEPT;
          r.msg_len = 24'(mlen);
          n = 1;
        end else begin
          ph = PH_WALK;
          nstart = 20;
        end
      end
    end else begin
      if (ph == PH_WALK && o >= nstart) begin
        s = nstart;
        rel = o - s;
        room = mlen - s;
        if (rel == 0 && room < 8) ph = PH_SHORT;
        else if (rel == 3) acode = shf;
        else if (rel == 4) vbit = b >> 7;
        else if (rel == 7) begin
          len = shf & MASK24;
          hdr = vbit ? 12 : 8;
          if (len < hdr || len > room) ph = PH_BADLEN;
          else begin
            stp = (len + 3) & ~32'd3;
            found = 1;
            f_code = acode;
            f_dlen = len - hdr;
            f_doff = s + hdr;
            nstart = (stp > room) ? mlen : s + stp;
          end
        end
      end
      if (o + 1 != mlen) begin
        if (last) begin
          r.kind = KIND_REJECT;
          r.reject_reason = RSN_HEADER;
          n = 1;
        end else if (found) begin
          r.kind = KIND_AVP;
          r.avp_code = f_code;
          r.avp_data_len = 24'(f_dlen);
          r.data_offset = 24'(f_doff);
          off = o + 1;
          return 1;
        end
      end else if (ph == PH_WALK) begin
        r.kind = KIND_ACCEPT;
        r.avp_code = f_code;
        r.avp_data_len = 24'(f_dlen);
        r.data_offset = 24'(f_doff);
        r.msg_len = 24'(mlen);
        n = 1;
      end else begin
        r.kind = KIND_REJECT;
        r.reject_reason = (ph == PH_SHORT) ? RSN_SHORT : RSN_BADLEN;
        n = 1;
      end
    end
    if (n) begin
      if (last) walker_restart();
      else ph = PH_DONE;
    end else begin
      off = (o + 1) & MASK24;
    end
    return n;
  endfunction

  // input acceptance, prediction and result checking on the rising edge
  always @(posedge clk) begin
    result_t want;
    result_t got;
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (in_fire && parse_byte(in_ch.data_byte, in_ch.buffer_end, want))
      results_due.push_back(want);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind = out_ch.kind;
      got.avp_code = out_ch.avp_code;
      got.avp_data_len = out_ch.avp_data_len;
      got.data_offset = out_ch.data_offset;
      got.msg_len = out_ch.msg_len;
      got.reject_reason = out_ch.reject_reason;
      if (results_due.size() == 0) begin
        $error("unexpected result word kind=%0d", got.kind);
        failed = 1;
      end else begin
        want = results_due.pop_front();
        if (got.kind !== want.kind) begin
          $error("kind: expected %0d actual %0d", want.kind, got.kind);
          failed = 1;
        end
        if (got.avp_code !== want.avp_code) begin
          $error("avp_code: expected %0h actual %0h", want.avp_code, got.avp_code);
          failed = 1;
        end
        if (got.avp_data_len !== want.avp_data_len) begin
          $error("avp_data_len: expected %0d actual %0d", want.avp_data_len,
                 got.avp_data_len);
          failed = 1;
        end
        if (got.data_offset !== want.data_offset) begin
          $error("data_offset: expected %0d actual %0d", want.data_offset,
                 got.data_offset);
          failed = 1;
        end
        if (got.msg_len !== want.msg_len) begin
          $error("msg_len: expected %0d actual %0d", want.msg_len, got.msg_len);
          failed = 1;
        end
        if (got.reject_reason !== want.reject_reason) begin
          $error("reject_reason: expected %0d actual %0d", want.reject_reason,
                 got.reject_reason);
          failed = 1;
        end
      end
      out_stall = calm ? 0 : $urandom_range(0, 14);
    end
  end

  // drive the next word on the falling edge, holding it until taken
  always @(negedge clk) begin
    msg_byte_t w;
    if (rst_n && (!in_ch.valid || in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (byte_stream.size() > 0) begin
        w = byte_stream.pop_front();
        in_ch.data_byte <= w.b;
        in_ch.buffer_end <= w.e;
        in_ch.valid <= 1'b1;
        bytes_sent++;
        in_gap = calm ? 0 : $urandom_range(0, 14);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    if (rst_n) begin
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == {REG_CMD, 2'b00}) cmd_reg = data[23:0];
    else app_reg = data;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic push_buffer(input logic [7:0] m[$]);
    msg_byte_t w;
    for (int i = 0; i < m.size(); i++) begin
      w.b = m[i];
      w.e = (i == m.size() - 1);
      byte_stream.push_back(w);
    end
  endtask

  function automatic void put_be(ref logic [7:0] m[$], input int unsigned v,
                                 input int nb);
    for (int i = nb - 1; i >= 0; i--) m.push_back(8'(v >> (8 * i)));
  endfunction

  // build one request buffer; damage picks the kind of fault, 0 for none
  task automatic queue_request(input int n_avp, input int damage);
    logic [7:0]  body[$];
    logic [7:0]  m[$];
    logic [7:0]  flags;
    int unsigned len;
    int unsigned hdr;
    int unsigned dlen;
    int          pos;
    for (int a = 0; a < n_avp; a++) begin
      flags = 8'($urandom());
      hdr = flags[7] ? 12 : 8;
      dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
      len = hdr + dlen;
      put_be(body, ($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 600)), 4);
      body.push_back(flags);
      if (damage == 3 && a == n_avp - 1)
        put_be(body, ($urandom_range(0, 1) ? $urandom_range(0, hdr - 1) : MASK24), 3);
      else
        put_be(body, len, 3);
      if (flags[7]) put_be(body, $urandom(), 4);
      for (int i = 0; i < dlen; i++) body.push_back(8'($urandom()));
      while (body.size() % 4 != 0) body.push_back(8'($urandom()));
    end
    // leave a tail too short for an AVP header
    if (damage == 4) put_be(body, $urandom(), 4);
    m.push_back(8'd1);
    put_be(m, 20 + body.size(), 3);
    m.push_back({1'b1, 7'($urandom())});
    put_be(m, cmd_reg, 3);
    put_be(m, app_reg, 4);
    put_be(m, $urandom(), 4);
    put_be(m, $urandom(), 4);
    foreach (body[i]) m.push_back(body[i]);
    case (damage)
      1: begin
        pos = $urandom_range(0, 19);
        m[pos] = m[pos] ^ (8'd1 << $urandom_range(0, 7));
      end
      2: begin
        pos = $urandom_range(1, m.size() - 1);
        while (m.size() > pos) void'(m.pop_back());
      end
      5: repeat ($urandom_range(1, 8)) m.push_back(8'($urandom()));
      6: begin
        m.delete();
        repeat ($urandom_range(1, 30)) m.push_back(8'($urandom()));
      end
      default: ;
    endcase
    push_buffer(m);
  endtask

  task automatic settle();
    while (byte_stream.size() > 0 || results_due.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    logic [7:0]  m[$];
    logic [23:0] cmds[5];
    logic [31:0] apps[5];
    int          dmg;
    failed = 0;
    in_fire = 0;
    calm = 0;
    in_gap = 0;
    out_stall = 0;
    bytes_sent = 0;
    cmd_reg = CmdReset;
    app_reg = AppReset;
    walker_restart();
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.buffer_end = 1'b0;
    out_ch.ready = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // bad version, short length, missing request bit, bare 20-byte request
    m = '{8'h02};
    push_buffer(m);
    m = '{8'h01, 8'h00, 8'h00, 8'h13};
    push_buffer(m);
    m = '{8'h01, 8'h00, 8'h00, 8'h14, 8'h7F};
    push_buffer(m);
    queue_request(0, 0);
    settle();

    cmds = '{24'd272, 24'd0, 24'hFFFFFF, 24'($urandom()), 24'd272};
    apps = '{32'd4, 32'd0, 32'hFFFFFFFF, $urandom(), 32'd4};
    for (int p = 0; p < 5; p++) begin
      reg_write({REG_CMD, 2'b00}, {8'h00, cmds[p]});
      reg_write({REG_APP, 2'b00}, apps[p]);
      while (bytes_sent < 30 + 370 * (p + 1)) begin
        calm = ($urandom_range(0, 5) == 0);
        dmg = $urandom_range(0, 13);
        queue_request($urandom_range(0, 5), (dmg > 6) ? 0 : dmg);
        while (byte_stream.size() > 40) @(posedge clk);
      end
      settle();
    end

    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
